[sv/blp_pkg.sv]
// ----------------------------------------------------------------------------
// blp_pkg
// Shared types and constants for the RGB565 masked line packer.
// ----------------------------------------------------------------------------
package blp_pkg;

    localparam int MAX_LINE_PIXELS = 1024;
    localparam int MAX_LINES       = 256;
    localparam int FILL_MAX        = 32;
    localparam int HEADER_WORDS    = 4;

    localparam int COL_W  = 10;
    localparam int ROW_W  = 8;
    localparam int LINE_W = 11;
    localparam int LINES_W = 9;
    localparam int FILL_W = 6;
    localparam int WORD_W = 32;
    localparam int PIX_W  = 16;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    localparam logic [WORD_W-1:0] HEADER_WORD0 = 32'h88AACCFF;

    localparam logic [LINE_W-1:0]  RST_LINE_PIXELS  = 11'd960;
    localparam logic [LINES_W-1:0] RST_FRAME_LINES  = 9'd160;
    localparam logic [FILL_W-1:0]  RST_FILLER_WORDS = 6'd32;
    localparam logic [WORD_W-1:0]  RST_XOR_MASK     = 32'hFFE7F3E7;

    typedef enum logic [1:0] {
        REG_LINE_PIXELS  = 2'd0,
        REG_FRAME_LINES  = 2'd1,
        REG_FILLER_WORDS = 2'd2,
        REG_XOR_MASK     = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_FILLER = 2'd2
    } t_kind;

    typedef struct packed {
        logic [LINE_W-1:0]  line_pixels;
        logic [LINES_W-1:0] frame_lines;
        logic [FILL_W-1:0]  filler_words;
        logic [WORD_W-1:0]  xor_mask;
    } t_cfg;

    typedef struct packed {
        logic              is_header;
        logic [WORD_W-1:0] data;
        logic              line_end;
        logic              frame_end;
    } t_cmd;

endpackage

[sv/blp_front.sv]
// ----------------------------------------------------------------------------
// blp_front
// Tracks column and row, packs pixels to RGB565, pairs them and issues
// header and pixel-pair commands to the queue.
// ----------------------------------------------------------------------------
module blp_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  blp_pkg::t_cfg         i_cfg,
    input  logic                  i_accept,
    input  logic [7:0]            i_first_channel,
    input  logic [7:0]            i_second_channel,
    input  logic [7:0]            i_third_channel,
    output logic                  o_push,
    output blp_pkg::t_cmd         o_cmd
);

    logic [blp_pkg::COL_W-1:0]   r_column, n_column;
    logic [blp_pkg::ROW_W-1:0]   r_row, n_row;
    logic [blp_pkg::PIX_W-1:0]   r_held, n_held;

    logic [blp_pkg::PIX_W-1:0]   pix;
    logic [blp_pkg::LINE_W-1:0]  lp_even, eff_line;
    logic [blp_pkg::LINES_W-1:0] eff_lines;
    logic                        line_end, frame_end, frame_start;

    always_comb begin
        pix = {i_first_channel[7:3], i_second_channel[7:2], i_third_channel[7:3]};
        lp_even = {i_cfg.line_pixels[blp_pkg::LINE_W-1:1], 1'b0};
        if (lp_even < blp_pkg::LINE_W'(2)) begin
            eff_line = blp_pkg::LINE_W'(2);
        end else if (lp_even > blp_pkg::LINE_W'(blp_pkg::MAX_LINE_PIXELS)) begin
            eff_line = blp_pkg::LINE_W'(blp_pkg::MAX_LINE_PIXELS);
        end else begin
            eff_line = lp_even;
        end
        if (i_cfg.frame_lines == '0) begin
            eff_lines = blp_pkg::LINES_W'(1);
        end else if (i_cfg.frame_lines > blp_pkg::LINES_W'(blp_pkg::MAX_LINES)) begin
            eff_lines = blp_pkg::LINES_W'(blp_pkg::MAX_LINES);
        end else begin
            eff_lines = i_cfg.frame_lines;
        end
        line_end    = (blp_pkg::LINE_W'(r_column) + blp_pkg::LINE_W'(1)) >= eff_line;
        frame_end   = line_end &&
                      ((blp_pkg::LINES_W'(r_row) + blp_pkg::LINES_W'(1)) >= eff_lines);
        frame_start = (r_column == '0) && (r_row == '0);
    end

    always_comb begin
        n_column = r_column;
        n_row    = r_row;
        n_held   = r_held;
        o_push   = 1'b0;
        o_cmd.is_header = 1'b0;
        o_cmd.data      = {pix, r_held};
        o_cmd.line_end  = line_end;
        o_cmd.frame_end = frame_end;
        if (i_accept) begin
            if (!r_column[0]) begin
                n_held   = pix;
                n_column = r_column + 1'b1;
                if (frame_start) begin
                    o_push          = 1'b1;
                    o_cmd.is_header = 1'b1;
                end
            end else begin
                o_push = 1'b1;
                if (line_end) begin
                    n_column = '0;
                    n_row    = frame_end ? '0 : r_row + 1'b1;
                end else begin
                    n_column = r_column + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
            r_row    <= '0;
            r_held   <= '0;
        end else begin
            r_column <= n_column;
            r_row    <= n_row;
            r_held   <= n_held;
        end
    end

    a_line_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_column[0] && line_end) |=> (r_column == '0))
        else $error("column did not wrap at line end");

    a_header_only_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_cmd.is_header) |-> (r_column == '0 && r_row == '0))
        else $error("header issued away from frame start");

endmodule

[sv/blp_queue.sv]
// ----------------------------------------------------------------------------
// blp_queue
// Small command queue between the front and the back.
// ----------------------------------------------------------------------------
module blp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  blp_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output blp_pkg::t_cmd o_cmd
);

    blp_pkg::t_cmd                r_mem [blp_pkg::Q_DEPTH];
    logic [blp_pkg::Q_AW-1:0]     r_wptr, r_rptr;
    logic [blp_pkg::Q_CW-1:0]     r_count;
    logic                         do_push, do_pop;

    assign o_full  = (r_count == blp_pkg::Q_CW'(blp_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + blp_pkg::Q_CW'(do_push) - blp_pkg::Q_CW'(do_pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= blp_pkg::Q_CW'(blp_pkg::Q_DEPTH))
        else $error("queue count overflow");

endmodule

[sv/blp_back.sv]
// ----------------------------------------------------------------------------
// blp_back
// Expands queued commands into header, masked pixel and filler words and
// holds them in the output register.
// ----------------------------------------------------------------------------
module blp_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  blp_pkg::t_cfg               i_cfg,
    input  logic                        i_cmd_valid,
    input  blp_pkg::t_cmd               i_cmd,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [blp_pkg::WORD_W-1:0]  o_word,
    output logic [1:0]                  o_kind,
    output logic                        o_last_of_run,
    output logic                        o_end_of_frame
);

    logic [blp_pkg::FILL_W-1:0] r_idx, n_idx;
    logic                       r_valid;
    logic [blp_pkg::WORD_W-1:0] r_word, n_word;
    blp_pkg::t_kind             r_kind, n_kind;
    logic                       r_last, n_last;
    logic                       r_eof, n_eof;

    logic [blp_pkg::FILL_W-1:0] fill, last_idx;
    logic                       emit, at_last;

    always_comb begin
        fill = (i_cfg.filler_words > blp_pkg::FILL_W'(blp_pkg::FILL_MAX)) ?
               blp_pkg::FILL_W'(blp_pkg::FILL_MAX) : i_cfg.filler_words;
        if (i_cmd.is_header) begin
            last_idx = blp_pkg::FILL_W'(blp_pkg::HEADER_WORDS - 1);
        end else if (i_cmd.line_end) begin
            last_idx = fill;
        end else begin
            last_idx = '0;
        end
        at_last = (r_idx == last_idx);
        emit    = i_cmd_valid && (!r_valid || !i_out_stall);
        o_pop   = emit && at_last;
        n_idx   = r_idx;
        if (emit) begin
            n_idx = at_last ? '0 : r_idx + 1'b1;
        end
    end

    always_comb begin
        if (i_cmd.is_header) begin
            n_word = (r_idx == '0) ? blp_pkg::HEADER_WORD0 : '0;
            n_kind = blp_pkg::KIND_HEADER;
            n_last = at_last;
            n_eof  = 1'b0;
        end else if (r_idx == '0) begin
            n_word = i_cmd.data ^ i_cfg.xor_mask;
            n_kind = blp_pkg::KIND_PIXEL;
            n_last = at_last;
            n_eof  = at_last && i_cmd.line_end && i_cmd.frame_end;
        end else begin
            n_word = i_cfg.xor_mask;
            n_kind = blp_pkg::KIND_FILLER;
            n_last = at_last;
            n_eof  = at_last && i_cmd.frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_word <= n_word;
            r_kind <= n_kind;
            r_last <= n_last;
            r_eof  <= n_eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_idx <= n_idx;
            if (emit) begin
                r_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_valid;
    assign o_word         = r_word;
    assign o_kind         = r_kind;
    assign o_last_of_run  = r_last;
    assign o_end_of_frame = r_eof;

    a_filler_needs_line_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_valid && !i_cmd.is_header && r_idx != '0) |-> i_cmd.line_end)
        else $error("filler index on a mid-line pixel pair");

    a_eof_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_eof) |-> r_last)
        else $error("end of frame on a word that is not last of run");

endmodule

[sv/bgra_to_rgb565_masked_line_packer.sv]
// ----------------------------------------------------------------------------
// bgra_to_rgb565_masked_line_packer
// Packs pixels to RGB565 pairs, XOR-masks them, adds per-line filler words
// and a four-word header at each frame start.
// ----------------------------------------------------------------------------
// Path: with an empty queue, the command caused by an accepted pixel is written
// into the queue, then its word into the output register, where it is taken.
// Throughput: one pixel per cycle unless the queue is full; the back emits one
// word per cycle unless stalled: four per header, one plus filler per line end.
// Reset: synchronous, active low; clears column, row, held pixel, queue and
// output valid, and loads the register defaults.
// ----------------------------------------------------------------------------
module bgra_to_rgb565_masked_line_packer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [blp_pkg::WORD_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [7:0]                  i_first_channel,
    input  logic [7:0]                  i_second_channel,
    input  logic [7:0]                  i_third_channel,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [blp_pkg::WORD_W-1:0]  o_word,
    output logic [1:0]                  o_kind,
    output logic                        o_last_of_run,
    output logic                        o_end_of_frame
);

    blp_pkg::t_cfg r_cfg;
    blp_pkg::t_cmd front_cmd, head_cmd;
    logic          push, pop, q_full, q_valid, in_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_pixels  <= blp_pkg::RST_LINE_PIXELS;
            r_cfg.frame_lines  <= blp_pkg::RST_FRAME_LINES;
            r_cfg.filler_words <= blp_pkg::RST_FILLER_WORDS;
            r_cfg.xor_mask     <= blp_pkg::RST_XOR_MASK;
        end else if (i_cfg_we) begin
            unique case (blp_pkg::t_reg_idx'(i_cfg_idx))
                blp_pkg::REG_LINE_PIXELS: begin
                    r_cfg.line_pixels <= i_cfg_data[blp_pkg::LINE_W-1:0];
                end
                blp_pkg::REG_FRAME_LINES: begin
                    r_cfg.frame_lines <= i_cfg_data[blp_pkg::LINES_W-1:0];
                end
                blp_pkg::REG_FILLER_WORDS: begin
                    r_cfg.filler_words <= i_cfg_data[blp_pkg::FILL_W-1:0];
                end
                blp_pkg::REG_XOR_MASK: begin
                    r_cfg.xor_mask <= i_cfg_data;
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    blp_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_accept         (in_accept),
        .i_first_channel  (i_first_channel),
        .i_second_channel (i_second_channel),
        .i_third_channel  (i_third_channel),
        .o_push           (push),
        .o_cmd            (front_cmd)
    );

    blp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    blp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_cmd_valid    (q_valid),
        .i_cmd          (head_cmd),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_word         (o_word),
        .o_kind         (o_kind),
        .o_last_of_run  (o_last_of_run),
        .o_end_of_frame (o_end_of_frame)
    );

endmodule
